### hw/rtl/icmp_pkg.sv
// ----------------------------------------------------------------------------
// icmp_pkg
// Constants for the ICMP reply parser: message types, length bounds, field positions and the IHL helper.
// ----------------------------------------------------------------------------
package icmp_pkg;

  localparam logic [7:0] V4_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] V4_ECHO_REQUEST  = 8'd8;
  localparam logic [7:0] V4_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0] V6_ECHO_REPLY    = 8'd129;
  localparam logic [7:0] V6_ECHO_REQUEST  = 8'd128;
  localparam logic [7:0] V6_TIME_EXCEEDED = 8'd3;

  // ICMP header + minimal inner IPv4 header + inner ICMP header
  localparam logic [16:0] V4_TE_MIN = 17'd36;
  // ICMPv6 header + unused word + inner IPv6 header + inner ICMPv6 header
  localparam logic [16:0] V6_TE_MIN = 17'd56;
  localparam logic [16:0] V4_MIN_LEN = 17'd20;
  localparam logic [16:0] V6_MIN_LEN = 17'd8;
  localparam logic [16:0] ICMP_HDR_LEN = 17'd8;

  localparam logic [15:0] OFFSET_MAX = 16'hffff;

  // IPv4 source address byte positions
  localparam logic [15:0] SRC_OFF_0 = 16'd12;
  localparam logic [15:0] SRC_OFF_3 = 16'd15;

  // fixed ICMPv6 field positions
  localparam logic [15:0] V6_OFF_ID_HI    = 16'd4;
  localparam logic [15:0] V6_OFF_INNER_TY = 16'd48;
  localparam logic [15:0] V6_OFF_INNER_ID = 16'd52;

  // IHL nibble to header length in bytes
  function automatic logic [5:0] ihl_bytes(input logic [7:0] b);
    ihl_bytes = {b[3:0], 2'b00};
  endfunction

endpackage

### hw/rtl/icmp_reply_parser.sv
// ----------------------------------------------------------------------------
// icmp_reply_parser
// Byte-stream parser that recognizes ICMP echo replies and time-exceeded
// messages carrying an echo request, and reports identifier, sequence and IPv4 source.
// ----------------------------------------------------------------------------
//
//   channel   dir   tdata                              tuser                  tlast
//   s_*       in    [7:0] data_byte                    [0] is_ipv6            last_byte
//   m_*       out   [15:0] id, [31:16] seq, [63:32]    [0] valid_res,         -
//                   source_ipv4                        [1] ttl_expired
//
// One byte is accepted per clock while s_tready is high; captures are done
// by offset compares, and the final checks between the parse and result registers.
// A result is produced only for a byte accepted with tlast set, in the next cycle.
// The result register holds while m_tready is low; s_tready drops only when
// it is full and not being taken.
// rst is synchronous and clears the parse state and the result valid flag.
module icmp_reply_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  input  logic        s_tuser,   // [0] is_ipv6
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [15:0] echo_identifier, [31:16] echo_sequence,
                                 // [63:32] source_ipv4
  output logic [1:0]  m_tuser    // [0] valid_res, [1] ttl_expired
);

  logic [15:0] byte_offset;
  logic        packet_family_v6;
  logic [5:0]  outer_header_len;
  logic [5:0]  inner_header_len;
  logic [7:0]  message_type;
  logic [7:0]  message_code;
  logic [15:0] reply_identifier;
  logic [15:0] reply_sequence;
  logic [7:0]  inner_type;
  logic [15:0] inner_identifier;
  logic [15:0] inner_sequence;
  logic [31:0] source_address;

  logic        packet_family_v6_next;
  logic [5:0]  outer_header_len_next;
  logic [5:0]  inner_header_len_next;
  logic [7:0]  message_type_next;
  logic [7:0]  message_code_next;
  logic [15:0] reply_identifier_next;
  logic [15:0] reply_sequence_next;
  logic [7:0]  inner_type_next;
  logic [15:0] inner_identifier_next;
  logic [15:0] inner_sequence_next;
  logic [31:0] source_address_next;

  logic        accept;
  logic        first;
  logic [15:0] base;
  logic [15:0] inner_base;
  logic [16:0] pkt_len;
  logic [16:0] msg_len;
  logic        res_valid;
  logic        res_te;
  logic [15:0] res_id;
  logic [15:0] res_seq;
  logic [31:0] res_src;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign first    = (byte_offset == 16'd0);

  // field captures for the current byte
  always_comb begin
    packet_family_v6_next = first ? s_tuser : packet_family_v6;
    outer_header_len_next = first ? icmp_pkg::ihl_bytes(s_tdata) : outer_header_len;
    inner_header_len_next = inner_header_len;
    message_type_next     = message_type;
    message_code_next     = message_code;
    reply_identifier_next = reply_identifier;
    reply_sequence_next   = reply_sequence;
    inner_type_next       = inner_type;
    inner_identifier_next = inner_identifier;
    inner_sequence_next   = inner_sequence;
    source_address_next   = source_address;
    base                  = {10'd0, outer_header_len_next};
    inner_base            = 16'd0;

    if (packet_family_v6_next) begin
      if (first) message_type_next = s_tdata;
      if (byte_offset == icmp_pkg::V6_OFF_ID_HI) reply_identifier_next[15:8] = s_tdata;
      if (byte_offset == icmp_pkg::V6_OFF_ID_HI + 16'd1) reply_identifier_next[7:0] = s_tdata;
      if (byte_offset == icmp_pkg::V6_OFF_ID_HI + 16'd2) reply_sequence_next[15:8] = s_tdata;
      if (byte_offset == icmp_pkg::V6_OFF_ID_HI + 16'd3) reply_sequence_next[7:0] = s_tdata;
      if (byte_offset == icmp_pkg::V6_OFF_INNER_TY) inner_type_next = s_tdata;
      if (byte_offset == icmp_pkg::V6_OFF_INNER_ID) inner_identifier_next[15:8] = s_tdata;
      if (byte_offset == icmp_pkg::V6_OFF_INNER_ID + 16'd1) inner_identifier_next[7:0] = s_tdata;
      if (byte_offset == icmp_pkg::V6_OFF_INNER_ID + 16'd2) inner_sequence_next[15:8] = s_tdata;
      if (byte_offset == icmp_pkg::V6_OFF_INNER_ID + 16'd3) inner_sequence_next[7:0] = s_tdata;
    end else begin
      if (byte_offset >= icmp_pkg::SRC_OFF_0 && byte_offset <= icmp_pkg::SRC_OFF_3) begin
        unique case (byte_offset[1:0])
          2'd0: source_address_next[31:24] = s_tdata;
          2'd1: source_address_next[23:16] = s_tdata;
          2'd2: source_address_next[15:8]  = s_tdata;
          2'd3: source_address_next[7:0]   = s_tdata;
        endcase
      end
      if (byte_offset == base) message_type_next = s_tdata;
      if (byte_offset == base + 16'd1) message_code_next = s_tdata;
      if (byte_offset == base + 16'd4) reply_identifier_next[15:8] = s_tdata;
      if (byte_offset == base + 16'd5) reply_identifier_next[7:0] = s_tdata;
      if (byte_offset == base + 16'd6) reply_sequence_next[15:8] = s_tdata;
      if (byte_offset == base + 16'd7) reply_sequence_next[7:0] = s_tdata;
      if (byte_offset == base + 16'd8) inner_header_len_next = icmp_pkg::ihl_bytes(s_tdata);
      // inner header length written on this byte already moves the inner base
      inner_base = base + 16'd8 + {10'd0, inner_header_len_next};
      if (byte_offset == inner_base) inner_type_next = s_tdata;
      if (byte_offset == inner_base + 16'd4) inner_identifier_next[15:8] = s_tdata;
      if (byte_offset == inner_base + 16'd5) inner_identifier_next[7:0] = s_tdata;
      if (byte_offset == inner_base + 16'd6) inner_sequence_next[15:8] = s_tdata;
      if (byte_offset == inner_base + 16'd7) inner_sequence_next[7:0] = s_tdata;
    end
  end

  // end-of-packet checks
  always_comb begin
    pkt_len   = {1'b0, byte_offset} + 17'd1;
    msg_len   = pkt_len - {11'd0, outer_header_len_next};
    res_valid = 1'b0;
    res_te    = 1'b0;
    res_id    = 16'd0;
    res_seq   = 16'd0;
    res_src   = 32'd0;
    if (packet_family_v6_next) begin
      if (pkt_len >= icmp_pkg::V6_MIN_LEN) begin
        priority if (message_type_next == icmp_pkg::V6_ECHO_REPLY) begin
          res_valid = 1'b1;
          res_id    = reply_identifier_next;
          res_seq   = reply_sequence_next;
        end else if (message_type_next == icmp_pkg::V6_TIME_EXCEEDED &&
                     pkt_len >= icmp_pkg::V6_TE_MIN &&
                     inner_type_next == icmp_pkg::V6_ECHO_REQUEST) begin
          res_valid = 1'b1;
          res_te    = 1'b1;
          res_id    = inner_identifier_next;
          res_seq   = inner_sequence_next;
        end
      end
    end else if (pkt_len >= icmp_pkg::V4_MIN_LEN &&
                 {11'd0, outer_header_len_next} <= pkt_len) begin
      res_src = source_address_next;
      if (msg_len >= icmp_pkg::ICMP_HDR_LEN) begin
        priority if (message_type_next == icmp_pkg::V4_ECHO_REPLY) begin
          res_valid = 1'b1;
          res_id    = reply_identifier_next;
          res_seq   = reply_sequence_next;
        end else if (message_type_next == icmp_pkg::V4_TIME_EXCEEDED &&
                     message_code_next == 8'd0 &&
                     msg_len >= icmp_pkg::V4_TE_MIN &&
                     ({11'd0, inner_header_len_next} + 17'd16) <= msg_len &&
                     inner_type_next == icmp_pkg::V4_ECHO_REQUEST) begin
          res_valid = 1'b1;
          res_te    = 1'b1;
          res_id    = inner_identifier_next;
          res_seq   = inner_sequence_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      // drop all parse state so the next byte opens a new packet
      byte_offset      <= 16'd0;
      packet_family_v6 <= 1'b0;
      outer_header_len <= 6'd0;
      inner_header_len <= 6'd0;
      message_type     <= 8'd0;
      message_code     <= 8'd0;
      reply_identifier <= 16'd0;
      reply_sequence   <= 16'd0;
      inner_type       <= 8'd0;
      inner_identifier <= 16'd0;
      inner_sequence   <= 16'd0;
      source_address   <= 32'd0;
    end else if (accept) begin
      if (byte_offset != icmp_pkg::OFFSET_MAX) byte_offset <= byte_offset + 16'd1;
      packet_family_v6 <= packet_family_v6_next;
      outer_header_len <= outer_header_len_next;
      inner_header_len <= inner_header_len_next;
      message_type     <= message_type_next;
      message_code     <= message_code_next;
      reply_identifier <= reply_identifier_next;
      reply_sequence   <= reply_sequence_next;
      inner_type       <= inner_type_next;
      inner_identifier <= inner_identifier_next;
      inner_sequence   <= inner_sequence_next;
      source_address   <= source_address_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      m_tdata <= {res_src, res_seq, res_id};
      m_tuser <= {res_te, res_valid};
    end
  end

  a_last_gives_result : assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> m_tvalid)
    else $error("last byte accepted without a result");

  a_last_clears_offset : assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> byte_offset == 16'd0)
    else $error("parse offset not cleared after end of packet");

  a_invalid_is_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[31:0] == 32'd0 && !m_tuser[1])
    else $error("invalid result carries identifier, sequence or type");

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while result is stalled");

endmodule
